// ===== rtl/ffba_pkg.sv =====
// Shared types, widths and codes for the first-fit block allocator.
package ffba_pkg;

  // Size and offset arithmetic width (covers the largest heap plus one header).
  localparam int SZ_W   = 17;
  // Block count width (covers the largest block table size itself).
  localparam int CNT_W  = 11;
  // Request and result field width.
  localparam int DATA_W = 12;

  localparam int HEAP_BYTES_DEF   = 4096;
  localparam int HEADER_BYTES_DEF = 9;
  localparam int MAX_BLOCKS_DEF   = 64;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NOROOM   = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  // One block table entry.
  typedef struct packed {
    logic            used;
    logic [SZ_W-1:0] size;
  } ffba_ent_t;

  // Request token that travels down the cell chain.
  typedef struct packed {
    logic              mode;
    logic [DATA_W-1:0] want;
    logic [DATA_W-1:0] addr;
    logic [SZ_W-1:0]   start;
    logic [SZ_W-1:0]   bytes;
    logic [CNT_W-1:0]  count;
    logic              done;
    logic [1:0]        status;
    logic [DATA_W-1:0] offset;
    logic              carry_v;
    ffba_ent_t         carry;
    logic              merge_v;
    logic              merge_seen;
    logic [SZ_W-1:0]   msize;
  } ffba_tok_t;

  // Broadcast control from the sequencer to all cells.
  typedef struct packed {
    logic            anchor_wr;
    logic            shl;
    logic [SZ_W-1:0] msize;
  } ffba_ctrl_t;

endpackage

// ===== rtl/ffba_cell.sv =====
// One block table cell: holds one entry and processes the passing request token.
module ffba_cell
  import ffba_pkg::*;
#(
  parameter int IDX          = 0,
  parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             tok_v_i,
  input  ffba_tok_t        tok_i,
  output logic             tok_v_o,
  output ffba_tok_t        tok_o,
  input  logic [CNT_W-1:0] count_i,
  input  ffba_ctrl_t       ctrl_i,
  input  ffba_ent_t        nb_i,
  output ffba_ent_t        ent_o
);

  localparam logic [SZ_W-1:0] Hdr = SZ_W'(HEADER_BYTES);

  ffba_ent_t ent_q, ent_d;
  ffba_tok_t tok_q, tok_d;
  logic      tok_v_q;
  logic      anchor_q, anchor_d;
  logic      shl_q, shl_d;
  logic      live;
  logic [SZ_W-1:0] rest;
  logic [SZ_W-1:0] poff;

  assign live = CNT_W'(IDX) < count_i;
  assign rest = ent_q.size - SZ_W'(tok_i.want);
  assign poff = tok_i.start + Hdr;

  // Token processing, then tail shift and merged size write-back
  always_comb begin
    tok_d    = tok_i;
    ent_d    = ent_q;
    anchor_d = anchor_q;
    shl_d    = shl_q;
    if (tok_v_i) begin
      anchor_d = 1'b0;
      shl_d    = tok_i.merge_seen;
      if (tok_i.carry_v) begin
        // ripple insert: take the carried entry, pass ours on
        ent_d       = tok_i.carry;
        tok_d.carry = ent_q;
      end else if (tok_i.merge_v) begin
        if (live && !ent_q.used) begin
          tok_d.msize = tok_i.msize + ent_q.size + Hdr;
          tok_d.bytes = tok_i.bytes - Hdr;
          tok_d.count = tok_i.count - CNT_W'(1);
        end else begin
          tok_d.merge_v = 1'b0;
        end
      end else if (!tok_i.done && live) begin
        if (tok_i.mode == MODE_ALLOC) begin
          if (!ent_q.used && ent_q.size >= SZ_W'(tok_i.want)) begin
            tok_d.done   = 1'b1;
            tok_d.status = ST_DONE;
            tok_d.offset = poff[DATA_W-1:0];
            ent_d.used   = 1'b1;
            if (rest >= Hdr && count_i < CNT_W'(MAX_BLOCKS)) begin
              // split: used part here, free remainder rippled behind
              ent_d.size         = SZ_W'(tok_i.want);
              tok_d.carry_v      = 1'b1;
              tok_d.carry.used   = 1'b0;
              tok_d.carry.size   = rest - Hdr;
              tok_d.count        = tok_i.count + CNT_W'(1);
              tok_d.bytes        = tok_i.bytes + SZ_W'(tok_i.want) + Hdr;
            end else begin
              tok_d.bytes = tok_i.bytes + ent_q.size;
            end
          end else begin
            tok_d.start = poff + ent_q.size;
          end
        end else begin
          if (poff == SZ_W'(tok_i.addr)) begin
            tok_d.done   = 1'b1;
            tok_d.offset = '0;
            if (ent_q.used) begin
              tok_d.status     = ST_DONE;
              ent_d.used       = 1'b0;
              tok_d.bytes      = tok_i.bytes - ent_q.size;
              tok_d.merge_v    = 1'b1;
              tok_d.merge_seen = 1'b1;
              tok_d.msize      = ent_q.size;
              anchor_d         = 1'b1;
            end else begin
              tok_d.status = ST_NOTFOUND;
            end
          end else begin
            tok_d.start = poff + ent_q.size;
          end
        end
      end
    end
    if (ctrl_i.shl && shl_q) begin
      ent_d = nb_i;
    end else if (ctrl_i.anchor_wr && anchor_q) begin
      ent_d.used = 1'b0;
      ent_d.size = ctrl_i.msize;
    end
  end

  // Entry and flag registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q.used <= 1'b0;
      ent_q.size <= (IDX == 0) ? SZ_W'(HEAP_BYTES - HEADER_BYTES) : '0;
      anchor_q   <= 1'b0;
      shl_q      <= 1'b0;
      tok_v_q    <= 1'b0;
    end else begin
      ent_q    <= ent_d;
      anchor_q <= anchor_d;
      shl_q    <= shl_d;
      tok_v_q  <= tok_v_i;
    end
  end

  // Token payload stage
  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  assign tok_v_o = tok_v_q;
  assign tok_o   = tok_q;
  assign ent_o   = ent_q;

endmodule

// ===== rtl/first_fit_block_allocator.sv =====
// First-fit block allocator top level: request sequencer and cell chain.
//
// A request is taken when start_i is high and busy_o is low. It walks a chain of
// MAX_BLOCKS cells, one cell per cycle, and the result is registered from
// the token leaving the last cell; a free that merges following free blocks first
// shifts the table tail in S_SHIFT. An allocate that cannot fit in the remaining
// heap bytes answers in the next cycle, with no walk. The result appears on
// payload_offset_o and status_o for exactly one cycle with result_valid_o; the
// next request can be taken in the strobe cycle. No clearing pass after reset.
module first_fit_block_allocator
  import ffba_pkg::*;
#(
  parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic              mode_i,
  input  logic [DATA_W-1:0] request_size_i,
  input  logic [DATA_W-1:0] address_i,
  output logic              result_valid_o,
  output logic [DATA_W-1:0] payload_offset_o,
  output logic [1:0]        status_o
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_WALK  = 3'b010,
    S_SHIFT = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [SZ_W-1:0]   bytes_q, bytes_d;
  logic [CNT_W-1:0]  sh_cnt_q, sh_cnt_d;
  logic              res_v_q, res_v_d;
  logic [DATA_W-1:0] res_off_q, res_off_d;
  logic [1:0]        res_st_q, res_st_d;
  logic              inj_v_q, inj_v_d;
  ffba_tok_t         inj_q, inj_d;
  logic              accept;
  logic              no_room;
  ffba_ctrl_t        ctrl;

  logic      tv   [MAX_BLOCKS+1];
  ffba_tok_t tk   [MAX_BLOCKS+1];
  ffba_ent_t ents [MAX_BLOCKS+1];

  assign accept  = start_i && (state_q == S_IDLE);
  assign no_room = SZ_W'(request_size_i) > (SZ_W'(HEAP_BYTES) - bytes_q);
  assign busy_o  = (state_q != S_IDLE);

  // Cell chain
  assign tv[0]             = inj_v_q;
  assign tk[0]             = inj_q;
  assign ents[MAX_BLOCKS]  = '0;

  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    ffba_cell #(
      .IDX         (g),
      .HEAP_BYTES  (HEAP_BYTES),
      .HEADER_BYTES(HEADER_BYTES),
      .MAX_BLOCKS  (MAX_BLOCKS)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_v_i(tv[g]),
      .tok_i  (tk[g]),
      .tok_v_o(tv[g+1]),
      .tok_o  (tk[g+1]),
      .count_i(count_q),
      .ctrl_i (ctrl),
      .nb_i   (ents[g+1]),
      .ent_o  (ents[g])
    );
  end

  // Broadcast control
  always_comb begin
    ctrl.anchor_wr = tv[MAX_BLOCKS] && tk[MAX_BLOCKS].merge_seen;
    ctrl.msize     = tk[MAX_BLOCKS].msize;
    ctrl.shl       = (state_q == S_SHIFT);
  end

  // Request sequencer
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    bytes_d   = bytes_q;
    sh_cnt_d  = sh_cnt_q;
    res_v_d   = 1'b0;
    res_off_d = res_off_q;
    res_st_d  = res_st_q;
    inj_v_d   = 1'b0;
    inj_d     = inj_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (mode_i == MODE_ALLOC && no_room) begin
            res_v_d   = 1'b1;
            res_off_d = '0;
            res_st_d  = ST_NOROOM;
          end else begin
            inj_v_d          = 1'b1;
            inj_d            = '0;
            inj_d.mode       = mode_i;
            inj_d.want       = request_size_i;
            inj_d.addr       = address_i;
            inj_d.bytes      = bytes_q;
            inj_d.count      = count_q;
            inj_d.status     = ST_DONE;
            state_d          = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (tv[MAX_BLOCKS]) begin
          count_d = tk[MAX_BLOCKS].count;
          bytes_d = tk[MAX_BLOCKS].bytes;
          if (tk[MAX_BLOCKS].done) begin
            res_off_d = tk[MAX_BLOCKS].offset;
            res_st_d  = tk[MAX_BLOCKS].status;
          end else begin
            res_off_d = '0;
            res_st_d  = (tk[MAX_BLOCKS].mode == MODE_FREE) ? ST_NOTFOUND : ST_NOROOM;
          end
          sh_cnt_d = count_q - tk[MAX_BLOCKS].count;
          if (tk[MAX_BLOCKS].merge_seen && (count_q != tk[MAX_BLOCKS].count)) begin
            state_d = S_SHIFT;
          end else begin
            res_v_d = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      S_SHIFT: begin
        sh_cnt_d = sh_cnt_q - CNT_W'(1);
        if (sh_cnt_q == CNT_W'(1)) begin
          res_v_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= CNT_W'(1);
      bytes_q  <= SZ_W'(HEADER_BYTES);
      sh_cnt_q <= '0;
      res_v_q  <= 1'b0;
      inj_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      bytes_q  <= bytes_d;
      sh_cnt_q <= sh_cnt_d;
      res_v_q  <= res_v_d;
      inj_v_q  <= inj_v_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    res_off_q <= res_off_d;
    res_st_q  <= res_st_d;
    inj_q     <= inj_d;
  end

  assign result_valid_o   = res_v_q;
  assign payload_offset_o = res_off_q;
  assign status_o         = res_st_q;

`ifndef SYNTHESIS
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (status_o == ST_DONE || status_o == ST_NOROOM ||
                        status_o == ST_NOTFOUND))
    else $error("invalid status code");

  a_fail_zero_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o != ST_DONE) |-> (payload_offset_o == '0))
    else $error("failed request with nonzero offset");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CNT_W'(1)) && (count_q <= CNT_W'(MAX_BLOCKS)))
    else $error("block count out of range");

  a_token_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tv[MAX_BLOCKS] |-> (state_q == S_WALK))
    else $error("token returned outside walk");
`endif

endmodule
